// ===== rtl/imp_pkg.sv =====
// ----------------------------------------------------------------------------
// imp_pkg
// shared types and constants of the instruction mix profiler: opcodes,
// kind codes, decode result and sequencer states
// ----------------------------------------------------------------------------
package imp_pkg;

    localparam int KIND_SLOTS = 52;
    localparam int REG_SLOTS  = 64;
    localparam int KIND_AW    = $clog2(KIND_SLOTS);
    localparam int REG_AW     = $clog2(REG_SLOTS);

    localparam logic [2:0] RM_RESET = 3'd7;

    typedef logic [KIND_AW-1:0] kind_t;
    typedef logic [REG_AW-1:0]  reg_idx_t;

    // major opcodes
    localparam logic [6:0] OPC_ZERO   = 7'h00;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_MULDIV = 7'h5B;
    localparam logic [6:0] OPC_RXBU   = 7'h0B;
    localparam logic [6:0] OPC_TXBU   = 7'h1B;
    localparam logic [6:0] OPC_FLW    = 7'h07;
    localparam logic [6:0] OPC_FSW    = 7'h27;
    localparam logic [6:0] OPC_FP     = 7'h53;

    // funct7 codes
    localparam logic [6:0] F7_ZERO   = 7'h00;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_FADD   = 7'h00;
    localparam logic [6:0] F7_FSUB   = 7'h04;
    localparam logic [6:0] F7_FMUL   = 7'h08;
    localparam logic [6:0] F7_FDIV   = 7'h0C;
    localparam logic [6:0] F7_FSQRT  = 7'h2C;
    localparam logic [6:0] F7_FSGNJ  = 7'h10;
    localparam logic [6:0] F7_FCVTSW = 7'h68;
    localparam logic [6:0] F7_FMVWX  = 7'h78;
    localparam logic [6:0] F7_FMVXW  = 7'h70;
    localparam logic [6:0] F7_FCMP   = 7'h50;

    // funct3 codes
    localparam logic [2:0] F3_ZERO = 3'd0;
    localparam logic [2:0] F3_ONE  = 3'd1;
    localparam logic [2:0] F3_TWO  = 3'd2;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_SHL  = 3'd1;
    localparam logic [2:0] F3_SHR  = 3'd5;
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [4:0] REG_ZERO = 5'd0;

    // instruction kinds
    localparam kind_t K_ZERO   = 6'd0;
    localparam kind_t K_LW     = 6'd1;
    localparam kind_t K_SW     = 6'd2;
    localparam kind_t K_SLL    = 6'd3;
    localparam kind_t K_SRL    = 6'd4;
    localparam kind_t K_SRA    = 6'd5;
    localparam kind_t K_ADD    = 6'd6;
    localparam kind_t K_SUB    = 6'd7;
    localparam kind_t K_XOR    = 6'd8;
    localparam kind_t K_OR     = 6'd9;
    localparam kind_t K_AND    = 6'd10;
    localparam kind_t K_SLT    = 6'd11;
    localparam kind_t K_SLTU   = 6'd12;
    localparam kind_t K_SLLI   = 6'd13;
    localparam kind_t K_SRLI   = 6'd14;
    localparam kind_t K_SRAI   = 6'd15;
    localparam kind_t K_ADDI   = 6'd16;
    localparam kind_t K_XORI   = 6'd17;
    localparam kind_t K_ORI    = 6'd18;
    localparam kind_t K_ANDI   = 6'd19;
    localparam kind_t K_SLTI   = 6'd20;
    localparam kind_t K_SLTIU  = 6'd21;
    localparam kind_t K_BEQ    = 6'd22;
    localparam kind_t K_BNE    = 6'd23;
    localparam kind_t K_BLT    = 6'd24;
    localparam kind_t K_BGE    = 6'd25;
    localparam kind_t K_BLTU   = 6'd26;
    localparam kind_t K_BGEU   = 6'd27;
    localparam kind_t K_LUI    = 6'd28;
    localparam kind_t K_AUIPC  = 6'd29;
    localparam kind_t K_JAL    = 6'd30;
    localparam kind_t K_JALR   = 6'd31;
    localparam kind_t K_MUL10  = 6'd32;
    localparam kind_t K_DIV10  = 6'd33;
    localparam kind_t K_RXBU   = 6'd34;
    localparam kind_t K_TXBU   = 6'd35;
    localparam kind_t K_FLW    = 6'd36;
    localparam kind_t K_FSW    = 6'd37;
    localparam kind_t K_FADD   = 6'd38;
    localparam kind_t K_FSUB   = 6'd39;
    localparam kind_t K_FMUL   = 6'd40;
    localparam kind_t K_FDIV   = 6'd41;
    localparam kind_t K_FSQRT  = 6'd42;
    localparam kind_t K_FSGNJ  = 6'd43;
    localparam kind_t K_FSGNJN = 6'd44;
    localparam kind_t K_FSGNJX = 6'd45;
    localparam kind_t K_FCVTSW = 6'd46;
    localparam kind_t K_FMVWX  = 6'd47;
    localparam kind_t K_FMVXW  = 6'd48;
    localparam kind_t K_FEQ    = 6'd49;
    localparam kind_t K_FLT    = 6'd50;
    localparam kind_t K_FLE    = 6'd51;

    localparam logic INT_FILE   = 1'b0;
    localparam logic FLOAT_FILE = 1'b1;

    typedef struct packed {
        logic     kind_valid;
        kind_t    kind;
        logic     use_rd;
        reg_idx_t rd;
        logic     use_rs1;
        reg_idx_t rs1;
        logic     use_rs2;
        reg_idx_t rs2;
    } dec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE,
        ST_SECOND,
        ST_REPLY
    } state_t;

endpackage

// ===== rtl/imp_decoder.sv =====
// ----------------------------------------------------------------------------
// imp_decoder
// maps opcode, funct3 and funct7 to an instruction kind and the register
// counter slots the instruction touches
// ----------------------------------------------------------------------------
module imp_decoder (
    input  logic [6:0]    opcode,
    input  logic [2:0]    funct3,
    input  logic [6:0]    funct7,
    input  logic [4:0]    dest_reg,
    input  logic [4:0]    src1_reg,
    input  logic [4:0]    src2_reg,
    input  logic [2:0]    rounding_mode,
    output imp_pkg::dec_t dec
);

    always_comb begin
        dec     = '0;
        dec.rd  = {imp_pkg::INT_FILE, dest_reg};
        dec.rs1 = {imp_pkg::INT_FILE, src1_reg};
        dec.rs2 = {imp_pkg::INT_FILE, src2_reg};
        unique case (opcode)
            imp_pkg::OPC_ZERO: begin
                dec.kind_valid = 1'b1;
                dec.kind       = imp_pkg::K_ZERO;
            end
            imp_pkg::OPC_LOAD: begin
                if (funct3 == imp_pkg::F3_WORD) begin
                    dec.use_rd     = 1'b1;
                    dec.use_rs1    = 1'b1;
                    dec.kind_valid = 1'b1;
                    dec.kind       = imp_pkg::K_LW;
                end
            end
            imp_pkg::OPC_STORE: begin
                if (funct3 == imp_pkg::F3_WORD) begin
                    dec.use_rs1    = 1'b1;
                    dec.use_rs2    = 1'b1;
                    dec.kind_valid = 1'b1;
                    dec.kind       = imp_pkg::K_SW;
                end
            end
            imp_pkg::OPC_OP: begin
                dec.use_rd     = 1'b1;
                dec.use_rs1    = 1'b1;
                dec.use_rs2    = 1'b1;
                dec.kind_valid = 1'b1;
                unique case (funct3)
                    imp_pkg::F3_SHL:  dec.kind = imp_pkg::K_SLL;
                    imp_pkg::F3_SHR: begin
                        dec.kind       = (funct7 == imp_pkg::F7_ALT) ? imp_pkg::K_SRA
                                                                     : imp_pkg::K_SRL;
                        dec.kind_valid = (funct7 == imp_pkg::F7_ZERO)
                                      || (funct7 == imp_pkg::F7_ALT);
                    end
                    imp_pkg::F3_ADD: begin
                        dec.kind       = (funct7 == imp_pkg::F7_ALT) ? imp_pkg::K_SUB
                                                                     : imp_pkg::K_ADD;
                        dec.kind_valid = (funct7 == imp_pkg::F7_ZERO)
                                      || (funct7 == imp_pkg::F7_ALT);
                    end
                    imp_pkg::F3_XOR:  dec.kind = imp_pkg::K_XOR;
                    imp_pkg::F3_OR:   dec.kind = imp_pkg::K_OR;
                    imp_pkg::F3_AND:  dec.kind = imp_pkg::K_AND;
                    imp_pkg::F3_SLT:  dec.kind = imp_pkg::K_SLT;
                    imp_pkg::F3_SLTU: dec.kind = imp_pkg::K_SLTU;
                    default:          dec.kind = imp_pkg::K_SLTU;
                endcase
            end
            imp_pkg::OPC_OPIMM: begin
                dec.use_rd     = 1'b1;
                dec.use_rs1    = 1'b1;
                dec.kind_valid = 1'b1;
                unique case (funct3)
                    imp_pkg::F3_SHL:  dec.kind = imp_pkg::K_SLLI;
                    imp_pkg::F3_SHR: begin
                        dec.kind       = (funct7 == imp_pkg::F7_ALT) ? imp_pkg::K_SRAI
                                                                     : imp_pkg::K_SRLI;
                        dec.kind_valid = (funct7 == imp_pkg::F7_ZERO)
                                      || (funct7 == imp_pkg::F7_ALT);
                    end
                    imp_pkg::F3_ADD:  dec.kind = imp_pkg::K_ADDI;
                    imp_pkg::F3_XOR:  dec.kind = imp_pkg::K_XORI;
                    imp_pkg::F3_OR:   dec.kind = imp_pkg::K_ORI;
                    imp_pkg::F3_AND:  dec.kind = imp_pkg::K_ANDI;
                    imp_pkg::F3_SLT:  dec.kind = imp_pkg::K_SLTI;
                    imp_pkg::F3_SLTU: dec.kind = imp_pkg::K_SLTIU;
                    default:          dec.kind = imp_pkg::K_SLTIU;
                endcase
            end
            imp_pkg::OPC_BRANCH: begin
                dec.use_rs1    = 1'b1;
                dec.use_rs2    = 1'b1;
                dec.kind_valid = 1'b1;
                unique case (funct3)
                    imp_pkg::F3_BEQ:  dec.kind = imp_pkg::K_BEQ;
                    imp_pkg::F3_BNE:  dec.kind = imp_pkg::K_BNE;
                    imp_pkg::F3_BLT:  dec.kind = imp_pkg::K_BLT;
                    imp_pkg::F3_BGE:  dec.kind = imp_pkg::K_BGE;
                    imp_pkg::F3_BLTU: dec.kind = imp_pkg::K_BLTU;
                    imp_pkg::F3_BGEU: dec.kind = imp_pkg::K_BGEU;
                    default:          dec.kind_valid = 1'b0;
                endcase
            end
            imp_pkg::OPC_LUI: begin
                dec.use_rd     = 1'b1;
                dec.kind_valid = 1'b1;
                dec.kind       = imp_pkg::K_LUI;
            end
            imp_pkg::OPC_AUIPC: begin
                dec.use_rd     = 1'b1;
                dec.kind_valid = 1'b1;
                dec.kind       = imp_pkg::K_AUIPC;
            end
            imp_pkg::OPC_JAL: begin
                dec.use_rd     = 1'b1;
                dec.kind_valid = 1'b1;
                dec.kind       = imp_pkg::K_JAL;
            end
            imp_pkg::OPC_JALR: begin
                dec.use_rd     = 1'b1;
                dec.use_rs1    = 1'b1;
                dec.kind_valid = 1'b1;
                dec.kind       = imp_pkg::K_JALR;
            end
            imp_pkg::OPC_MULDIV: begin
                dec.use_rd     = 1'b1;
                dec.use_rs1    = 1'b1;
                dec.kind       = (funct3 == imp_pkg::F3_ONE) ? imp_pkg::K_DIV10
                                                             : imp_pkg::K_MUL10;
                dec.kind_valid = (funct7 == imp_pkg::F7_ZERO)
                              && (src2_reg == imp_pkg::REG_ZERO)
                              && ((funct3 == imp_pkg::F3_ZERO) || (funct3 == imp_pkg::F3_ONE));
            end
            imp_pkg::OPC_RXBU: begin
                dec.use_rd     = 1'b1;
                dec.kind_valid = 1'b1;
                dec.kind       = imp_pkg::K_RXBU;
            end
            imp_pkg::OPC_TXBU: begin
                dec.use_rs1    = 1'b1;
                dec.kind_valid = 1'b1;
                dec.kind       = imp_pkg::K_TXBU;
            end
            imp_pkg::OPC_FLW: begin
                if (funct3 == imp_pkg::F3_WORD) begin
                    dec.rd         = {imp_pkg::FLOAT_FILE, dest_reg};
                    dec.use_rd     = 1'b1;
                    dec.use_rs1    = 1'b1;
                    dec.kind_valid = 1'b1;
                    dec.kind       = imp_pkg::K_FLW;
                end
            end
            imp_pkg::OPC_FSW: begin
                if (funct3 == imp_pkg::F3_WORD) begin
                    dec.rs2        = {imp_pkg::FLOAT_FILE, src2_reg};
                    dec.use_rs1    = 1'b1;
                    dec.use_rs2    = 1'b1;
                    dec.kind_valid = 1'b1;
                    dec.kind       = imp_pkg::K_FSW;
                end
            end
            imp_pkg::OPC_FP: begin
                dec.rd  = {imp_pkg::FLOAT_FILE, dest_reg};
                dec.rs1 = {imp_pkg::FLOAT_FILE, src1_reg};
                dec.rs2 = {imp_pkg::FLOAT_FILE, src2_reg};
                unique case (funct7)
                    imp_pkg::F7_FADD, imp_pkg::F7_FSUB, imp_pkg::F7_FMUL,
                    imp_pkg::F7_FDIV: begin
                        if (funct3 == rounding_mode) begin
                            dec.use_rd     = 1'b1;
                            dec.use_rs1    = 1'b1;
                            dec.use_rs2    = 1'b1;
                            dec.kind_valid = 1'b1;
                            dec.kind       = imp_pkg::K_FADD + imp_pkg::kind_t'(funct7[6:2]);
                        end
                    end
                    imp_pkg::F7_FSQRT: begin
                        if (funct3 == rounding_mode && src2_reg == imp_pkg::REG_ZERO) begin
                            dec.use_rd     = 1'b1;
                            dec.use_rs1    = 1'b1;
                            dec.kind_valid = 1'b1;
                            dec.kind       = imp_pkg::K_FSQRT;
                        end
                    end
                    imp_pkg::F7_FSGNJ: begin
                        dec.use_rd     = 1'b1;
                        dec.use_rs1    = 1'b1;
                        dec.use_rs2    = 1'b1;
                        dec.kind_valid = (funct3 <= imp_pkg::F3_TWO);
                        dec.kind       = imp_pkg::K_FSGNJ + imp_pkg::kind_t'(funct3);
                    end
                    imp_pkg::F7_FCVTSW: begin
                        if (funct3 == rounding_mode && src2_reg == imp_pkg::REG_ZERO) begin
                            dec.rs1        = {imp_pkg::INT_FILE, src1_reg};
                            dec.use_rd     = 1'b1;
                            dec.use_rs1    = 1'b1;
                            dec.kind_valid = 1'b1;
                            dec.kind       = imp_pkg::K_FCVTSW;
                        end
                    end
                    imp_pkg::F7_FMVWX: begin
                        if (funct3 == imp_pkg::F3_ZERO && src2_reg == imp_pkg::REG_ZERO) begin
                            dec.rs1        = {imp_pkg::INT_FILE, src1_reg};
                            dec.use_rd     = 1'b1;
                            dec.use_rs1    = 1'b1;
                            dec.kind_valid = 1'b1;
                            dec.kind       = imp_pkg::K_FMVWX;
                        end
                    end
                    imp_pkg::F7_FMVXW: begin
                        if (funct3 == imp_pkg::F3_ZERO && src2_reg == imp_pkg::REG_ZERO) begin
                            dec.rd         = {imp_pkg::INT_FILE, dest_reg};
                            dec.use_rd     = 1'b1;
                            dec.use_rs1    = 1'b1;
                            dec.kind_valid = 1'b1;
                            dec.kind       = imp_pkg::K_FMVXW;
                        end
                    end
                    imp_pkg::F7_FCMP: begin
                        dec.rd         = {imp_pkg::INT_FILE, dest_reg};
                        dec.use_rd     = 1'b1;
                        dec.use_rs1    = 1'b1;
                        dec.use_rs2    = 1'b1;
                        dec.kind_valid = (funct3 <= imp_pkg::F3_TWO);
                        dec.kind       = imp_pkg::K_FLE - imp_pkg::kind_t'(funct3);
                    end
                    default: dec.kind_valid = 1'b0;
                endcase
            end
            default: dec.kind_valid = 1'b0;
        endcase
    end

endmodule

// ===== rtl/instruction_mix_profiler.sv =====
// ----------------------------------------------------------------------------
// instruction_mix_profiler
// counts retired instructions per kind and register uses per register slot,
// keeps the peak heap pointer, and reads the counters back on request
// ----------------------------------------------------------------------------
// Each input transfer is either a record (tuser 0) or a read (tuser 1) and
// yields exactly one output transfer. The block works on one item at a time:
// an item passes from accept through memory lookup, read-modify-write of the
// kind, destination and first source counters and second source update to
// the reply, which waits while the output register is full. The second source
// update is a step of its own because all source counters share one
// memory with one write port; a repeated source is forwarded from the first
// update. Counters live in three memories, each with one read and one write
// port and registered reads, and are cleared at reset at once by per-entry
// valid bits, so no clearing pass is needed. The result sits in an output
// register, so the next item is accepted while a reply still waits. The
// rounding-mode register is written through the cfg channel, which is always
// ready.
module instruction_mix_profiler #(
    parameter int COUNT_BITS = 48
) (
    input  logic         aclk,
    input  logic         aresetn,
    // config write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_data,     // rounding_mode_code
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         s_tuser,      // op
    // opcode[6:0] funct3[9:7] funct7[16:10] dest_reg[21:17] src1_reg[26:22]
    // src2_reg[31:27] heap_value[63:32] heap_valid[64] read_index[70:65]
    input  logic [71:0]  s_tdata,
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic         m_tuser,      // status
    // kind_count[47:0] dest_count[95:48] src_count[143:96] heap_max[175:144]
    output logic [175:0] m_tdata
);

    typedef logic [COUNT_BITS-1:0] count_t;

    function automatic count_t sat_inc(input count_t value);
        return (&value) ? value : value + count_t'(1);
    endfunction

    imp_pkg::state_t state_reg, state_next;

    logic [2:0]  rm_reg;
    logic        op_reg;
    logic [6:0]  opcode_reg;
    logic [2:0]  funct3_reg;
    logic [6:0]  funct7_reg;
    logic [4:0]  dest_reg_reg;
    logic [4:0]  src1_reg_reg;
    logic [4:0]  src2_reg_reg;
    logic signed [31:0] heap_value_reg;
    logic        heap_valid_reg;
    logic [5:0]  read_index_reg;

    imp_pkg::dec_t dec;

    count_t kind_mem [imp_pkg::KIND_SLOTS];
    count_t dest_mem [imp_pkg::REG_SLOTS];
    count_t src_mem  [imp_pkg::REG_SLOTS];

    logic [imp_pkg::KIND_SLOTS-1:0] kind_vld_reg;
    logic [imp_pkg::REG_SLOTS-1:0]  dest_vld_reg;
    logic [imp_pkg::REG_SLOTS-1:0]  src_vld_reg;

    count_t kind_rd_reg, dest_rd_reg, src_rd_reg;
    logic   kind_hit_reg, dest_hit_reg, src_hit_reg;
    count_t fwd_val_reg;
    logic   fwd_hit_reg;

    count_t res_kind_reg, res_dest_reg, res_src_reg;
    logic   status_reg;
    logic signed [31:0] heap_peak_reg;

    logic         out_valid_reg;
    logic         out_user_reg;
    logic [175:0] out_data_reg;

    imp_pkg::kind_t    kind_raddr;
    imp_pkg::reg_idx_t dest_raddr, src_raddr, src_waddr;
    count_t kind_cur, dest_cur, src_cur, src_base;
    logic   is_record;
    logic   accept, do_lookup, do_update, do_second, out_load;
    logic   kind_we, dest_we, src_we, heap_we;

    imp_decoder u_decoder (
        .opcode        (opcode_reg),
        .funct3        (funct3_reg),
        .funct7        (funct7_reg),
        .dest_reg      (dest_reg_reg),
        .src1_reg      (src1_reg_reg),
        .src2_reg      (src2_reg_reg),
        .rounding_mode (rm_reg),
        .dec           (dec)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            imp_pkg::ST_IDLE:   if (s_tvalid) state_next = imp_pkg::ST_LOOKUP;
            imp_pkg::ST_LOOKUP: state_next = imp_pkg::ST_UPDATE;
            imp_pkg::ST_UPDATE: state_next = imp_pkg::ST_SECOND;
            imp_pkg::ST_SECOND: state_next = imp_pkg::ST_REPLY;
            imp_pkg::ST_REPLY:  if (!out_valid_reg || m_tready) state_next = imp_pkg::ST_IDLE;
            default:            state_next = imp_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready  = 1'b0;
        do_lookup = 1'b0;
        do_update = 1'b0;
        do_second = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            imp_pkg::ST_IDLE:   s_tready  = 1'b1;
            imp_pkg::ST_LOOKUP: do_lookup = 1'b1;
            imp_pkg::ST_UPDATE: do_update = 1'b1;
            imp_pkg::ST_SECOND: do_second = 1'b1;
            imp_pkg::ST_REPLY:  out_load  = !out_valid_reg || m_tready;
            default:            s_tready  = 1'b0;
        endcase
    end

    assign accept    = s_tvalid && s_tready;
    assign is_record = !op_reg;
    assign cfg_ready = 1'b1;

    assign kind_raddr = op_reg ? imp_pkg::kind_t'(read_index_reg) : dec.kind;
    assign dest_raddr = op_reg ? imp_pkg::reg_idx_t'(read_index_reg) : dec.rd;
    assign src_raddr  = do_lookup ? (op_reg ? imp_pkg::reg_idx_t'(read_index_reg) : dec.rs1)
                                  : dec.rs2;
    assign src_waddr  = do_second ? dec.rs2 : dec.rs1;

    assign kind_cur = kind_hit_reg ? kind_rd_reg : '0;
    assign dest_cur = dest_hit_reg ? dest_rd_reg : '0;
    assign src_cur  = src_hit_reg  ? src_rd_reg  : '0;
    assign src_base = (do_second && fwd_hit_reg) ? fwd_val_reg : src_cur;

    assign kind_we = do_update && is_record && dec.kind_valid;
    assign dest_we = do_update && is_record && dec.use_rd;
    assign src_we  = is_record && ((do_update && dec.use_rs1) || (do_second && dec.use_rs2));
    assign heap_we = kind_we && heap_valid_reg && (heap_value_reg > heap_peak_reg);

    // counter memories
    always_ff @(posedge aclk) begin
        if (kind_we) kind_mem[dec.kind] <= sat_inc(kind_cur);
        kind_rd_reg <= kind_mem[kind_raddr];
    end

    always_ff @(posedge aclk) begin
        if (dest_we) dest_mem[dec.rd] <= sat_inc(dest_cur);
        dest_rd_reg <= dest_mem[dest_raddr];
    end

    always_ff @(posedge aclk) begin
        if (src_we) src_mem[src_waddr] <= sat_inc(src_base);
        src_rd_reg <= src_mem[src_raddr];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= imp_pkg::ST_IDLE;
            rm_reg        <= imp_pkg::RM_RESET;
            kind_vld_reg  <= '0;
            dest_vld_reg  <= '0;
            src_vld_reg   <= '0;
            heap_peak_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) rm_reg <= cfg_data;
            if (kind_we) kind_vld_reg[dec.kind] <= 1'b1;
            if (dest_we) dest_vld_reg[dec.rd] <= 1'b1;
            if (src_we) src_vld_reg[src_waddr] <= 1'b1;
            if (heap_we) heap_peak_reg <= heap_value_reg;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg         <= s_tuser;
            opcode_reg     <= s_tdata[6:0];
            funct3_reg     <= s_tdata[9:7];
            funct7_reg     <= s_tdata[16:10];
            dest_reg_reg   <= s_tdata[21:17];
            src1_reg_reg   <= s_tdata[26:22];
            src2_reg_reg   <= s_tdata[31:27];
            heap_value_reg <= s_tdata[63:32];
            heap_valid_reg <= s_tdata[64];
            read_index_reg <= s_tdata[70:65];
        end
        kind_hit_reg <= (int'(kind_raddr) < imp_pkg::KIND_SLOTS) && kind_vld_reg[kind_raddr];
        dest_hit_reg <= dest_vld_reg[dest_raddr];
        src_hit_reg  <= src_vld_reg[src_raddr];
        if (do_update) begin
            fwd_hit_reg  <= is_record && dec.use_rs1 && (dec.rs1 == dec.rs2);
            fwd_val_reg  <= sat_inc(src_cur);
            status_reg   <= is_record && !dec.kind_valid;
            res_kind_reg <= op_reg ? kind_cur : '0;
            res_dest_reg <= op_reg ? dest_cur : '0;
            res_src_reg  <= op_reg ? src_cur  : '0;
        end
        if (out_load) begin
            out_user_reg <= status_reg;
            out_data_reg <= {heap_peak_reg, 48'(res_src_reg), 48'(res_dest_reg),
                             48'(res_kind_reg)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_user_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the instruction mix profiler: a queue-fed driver
// sends record and read transfers with random gaps, a monitor compares every
// result against an in-bench model of the kind, register-use and heap-peak
// counters, and the rounding-mode register is rewritten between phases
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   CNT_W          = 48;
    localparam logic OP_RECORD      = 1'b0;
    localparam logic OP_READ        = 1'b1;
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_UNKNOWN = 1'b1;
    localparam int   NO_KIND        = -1;
    localparam int   RANDOM_ITEMS   = 1850;
    localparam int   N_PHASES       = 5;
    localparam int   STALL_LIMIT    = 2000;
    localparam int   DRAIN_CYCLES   = 20;

    localparam logic [CNT_W-1:0] CNT_SAT = '1;

    typedef struct {
        logic               op;
        logic [6:0]         opcode;
        logic [2:0]         funct3;
        logic [6:0]         funct7;
        logic [4:0]         rd;
        logic [4:0]         rs1;
        logic [4:0]         rs2;
        logic signed [31:0] heap_value;
        logic               heap_valid;
        logic [5:0]         read_index;
    } retire_item_t;

    typedef struct {
        logic               status;
        logic [CNT_W-1:0]   kind_count;
        logic [CNT_W-1:0]   dest_count;
        logic [CNT_W-1:0]   src_count;
        logic signed [31:0] heap_max;
    } profile_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_data  = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic         s_tuser   = 1'b0;
    logic [71:0]  s_tdata   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic         m_tuser;
    logic [175:0] m_tdata;

    // model state
    logic [CNT_W-1:0]   kind_tally [imp_pkg::KIND_SLOTS];
    logic [CNT_W-1:0]   dest_tally [imp_pkg::REG_SLOTS];
    logic [CNT_W-1:0]   src_tally  [imp_pkg::REG_SLOTS];
    logic signed [31:0] heap_peak;
    logic [2:0]         round_mode;

    retire_item_t queued_instrs[$];
    profile_t     predicted_profiles[$];
    retire_item_t cur_item;
    logic         item_taken = 1'b0;

    logic [6:0] major_opcodes[$];
    logic [6:0] fp_functs[$];

    int send_idle_pct = 0;
    int take_idle_pct = 0;
    int send_gap      = 0;
    int take_stall    = 0;

    int mismatches      = 0;
    int results_checked = 0;
    int reads_sent      = 0;
    int records_sent    = 0;
    int rejected_items  = 0;

    instruction_mix_profiler u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic void count_dest(imp_pkg::reg_idx_t r);
        if (dest_tally[r] != CNT_SAT) dest_tally[r] = dest_tally[r] + 1'b1;
    endfunction

    function automatic void count_src(imp_pkg::reg_idx_t r);
        if (src_tally[r] != CNT_SAT) src_tally[r] = src_tally[r] + 1'b1;
    endfunction

    // register counters of some classes move before the field check rejects
    function automatic int decode_kind(retire_item_t it);
        int                k;
        imp_pkg::reg_idx_t xd, x1, x2, fd, f1, f2;
        k  = NO_KIND;
        xd = {imp_pkg::INT_FILE, it.rd};
        x1 = {imp_pkg::INT_FILE, it.rs1};
        x2 = {imp_pkg::INT_FILE, it.rs2};
        fd = {imp_pkg::FLOAT_FILE, it.rd};
        f1 = {imp_pkg::FLOAT_FILE, it.rs1};
        f2 = {imp_pkg::FLOAT_FILE, it.rs2};
        case (it.opcode)
            imp_pkg::OPC_ZERO: k = imp_pkg::K_ZERO;
            imp_pkg::OPC_LOAD: if (it.funct3 == imp_pkg::F3_WORD) begin
                count_dest(xd);
                count_src(x1);
                k = imp_pkg::K_LW;
            end
            imp_pkg::OPC_STORE: if (it.funct3 == imp_pkg::F3_WORD) begin
                count_src(x1);
                count_src(x2);
                k = imp_pkg::K_SW;
            end
            imp_pkg::OPC_OP: begin
                count_dest(xd);
                count_src(x1);
                count_src(x2);
                case (it.funct3)
                    imp_pkg::F3_SHL: k = imp_pkg::K_SLL;
                    imp_pkg::F3_SHR: begin
                        if (it.funct7 == imp_pkg::F7_ZERO) k = imp_pkg::K_SRL;
                        else if (it.funct7 == imp_pkg::F7_ALT) k = imp_pkg::K_SRA;
                    end
                    imp_pkg::F3_ADD: begin
                        if (it.funct7 == imp_pkg::F7_ZERO) k = imp_pkg::K_ADD;
                        else if (it.funct7 == imp_pkg::F7_ALT) k = imp_pkg::K_SUB;
                    end
                    imp_pkg::F3_XOR: k = imp_pkg::K_XOR;
                    imp_pkg::F3_OR:  k = imp_pkg::K_OR;
                    imp_pkg::F3_AND: k = imp_pkg::K_AND;
                    imp_pkg::F3_SLT: k = imp_pkg::K_SLT;
                    default:         k = imp_pkg::K_SLTU;
                endcase
            end
            imp_pkg::OPC_OPIMM: begin
                count_dest(xd);
                count_src(x1);
                case (it.funct3)
                    imp_pkg::F3_SHL: k = imp_pkg::K_SLLI;
                    imp_pkg::F3_SHR: begin
                        if (it.funct7 == imp_pkg::F7_ZERO) k = imp_pkg::K_SRLI;
                        else if (it.funct7 == imp_pkg::F7_ALT) k = imp_pkg::K_SRAI;
                    end
                    imp_pkg::F3_ADD: k = imp_pkg::K_ADDI;
                    imp_pkg::F3_XOR: k = imp_pkg::K_XORI;
                    imp_pkg::F3_OR:  k = imp_pkg::K_ORI;
                    imp_pkg::F3_AND: k = imp_pkg::K_ANDI;
                    imp_pkg::F3_SLT: k = imp_pkg::K_SLTI;
                    default:         k = imp_pkg::K_SLTIU;
                endcase
            end
            imp_pkg::OPC_BRANCH: begin
                count_src(x1);
                count_src(x2);
                case (it.funct3)
                    imp_pkg::F3_BEQ:  k = imp_pkg::K_BEQ;
                    imp_pkg::F3_BNE:  k = imp_pkg::K_BNE;
                    imp_pkg::F3_BLT:  k = imp_pkg::K_BLT;
                    imp_pkg::F3_BGE:  k = imp_pkg::K_BGE;
                    imp_pkg::F3_BLTU: k = imp_pkg::K_BLTU;
                    imp_pkg::F3_BGEU: k = imp_pkg::K_BGEU;
                    default: ;
                endcase
            end
            imp_pkg::OPC_LUI: begin
                count_dest(xd);
                k = imp_pkg::K_LUI;
            end
            imp_pkg::OPC_AUIPC: begin
                count_dest(xd);
                k = imp_pkg::K_AUIPC;
            end
            imp_pkg::OPC_JAL: begin
                count_dest(xd);
                k = imp_pkg::K_JAL;
            end
            imp_pkg::OPC_JALR: begin
                count_dest(xd);
                count_src(x1);
                k = imp_pkg::K_JALR;
            end
            imp_pkg::OPC_MULDIV: begin
                count_dest(xd);
                count_src(x1);
                if (it.funct7 == imp_pkg::F7_ZERO && it.rs2 == imp_pkg::REG_ZERO) begin
                    if (it.funct3 == imp_pkg::F3_ZERO) k = imp_pkg::K_MUL10;
                    else if (it.funct3 == imp_pkg::F3_ONE) k = imp_pkg::K_DIV10;
                end
            end
            imp_pkg::OPC_RXBU: begin
                count_dest(xd);
                k = imp_pkg::K_RXBU;
            end
            imp_pkg::OPC_TXBU: begin
                count_src(x1);
                k = imp_pkg::K_TXBU;
            end
            imp_pkg::OPC_FLW: if (it.funct3 == imp_pkg::F3_WORD) begin
                count_dest(fd);
                count_src(x1);
                k = imp_pkg::K_FLW;
            end
            imp_pkg::OPC_FSW: if (it.funct3 == imp_pkg::F3_WORD) begin
                count_src(x1);
                count_src(f2);
                k = imp_pkg::K_FSW;
            end
            imp_pkg::OPC_FP: begin
                case (it.funct7)
                    imp_pkg::F7_FADD, imp_pkg::F7_FSUB, imp_pkg::F7_FMUL,
                    imp_pkg::F7_FDIV: begin
                        if (it.funct3 == round_mode) begin
                            count_dest(fd);
                            count_src(f1);
                            count_src(f2);
                            k = int'(imp_pkg::K_FADD) + int'(it.funct7[6:2]);
                        end
                    end
                    imp_pkg::F7_FSQRT: begin
                        if (it.funct3 == round_mode && it.rs2 == imp_pkg::REG_ZERO) begin
                            count_dest(fd);
                            count_src(f1);
                            k = imp_pkg::K_FSQRT;
                        end
                    end
                    imp_pkg::F7_FSGNJ: begin
                        count_dest(fd);
                        count_src(f1);
                        count_src(f2);
                        if (it.funct3 <= imp_pkg::F3_TWO)
                            k = int'(imp_pkg::K_FSGNJ) + int'(it.funct3);
                    end
                    imp_pkg::F7_FCVTSW: begin
                        if (it.funct3 == round_mode && it.rs2 == imp_pkg::REG_ZERO) begin
                            count_dest(fd);
                            count_src(x1);
                            k = imp_pkg::K_FCVTSW;
                        end
                    end
                    imp_pkg::F7_FMVWX: begin
                        if (it.funct3 == imp_pkg::F3_ZERO && it.rs2 == imp_pkg::REG_ZERO) begin
                            count_dest(fd);
                            count_src(x1);
                            k = imp_pkg::K_FMVWX;
                        end
                    end
                    imp_pkg::F7_FMVXW: begin
                        if (it.funct3 == imp_pkg::F3_ZERO && it.rs2 == imp_pkg::REG_ZERO) begin
                            count_dest(xd);
                            count_src(f1);
                            k = imp_pkg::K_FMVXW;
                        end
                    end
                    imp_pkg::F7_FCMP: begin
                        count_dest(xd);
                        count_src(f1);
                        count_src(f2);
                        if (it.funct3 <= imp_pkg::F3_TWO)
                            k = int'(imp_pkg::K_FLE) - int'(it.funct3);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        return k;
    endfunction

    function automatic profile_t predict_profile(retire_item_t it);
        profile_t res;
        int       k;
        res.status     = STATUS_OK;
        res.kind_count = '0;
        res.dest_count = '0;
        res.src_count  = '0;
        if (it.op == OP_READ) begin
            if (it.read_index < imp_pkg::KIND_SLOTS)
                res.kind_count = kind_tally[it.read_index];
            res.dest_count = dest_tally[it.read_index];
            res.src_count  = src_tally[it.read_index];
        end else begin
            k = decode_kind(it);
            if (k == NO_KIND) begin
                res.status = STATUS_UNKNOWN;
                rejected_items++;
            end else begin
                if (kind_tally[k] != CNT_SAT) kind_tally[k] = kind_tally[k] + 1'b1;
                if (it.heap_valid && it.heap_value > heap_peak) heap_peak = it.heap_value;
            end
        end
        res.heap_max = heap_peak;
        return res;
    endfunction

    function automatic retire_item_t record_item(logic [6:0] opc, logic [2:0] f3,
                                                 logic [6:0] f7, logic [4:0] rd,
                                                 logic [4:0] rs1, logic [4:0] rs2,
                                                 logic signed [31:0] hv, logic hvalid);
        retire_item_t it;
        it.op         = OP_RECORD;
        it.opcode     = opc;
        it.funct3     = f3;
        it.funct7     = f7;
        it.rd         = rd;
        it.rs1        = rs1;
        it.rs2        = rs2;
        it.heap_value = hv;
        it.heap_valid = hvalid;
        it.read_index = 6'($urandom_range(0, 63));
        return it;
    endfunction

    function automatic retire_item_t read_item(logic [5:0] idx);
        retire_item_t it;
        it            = record_item(7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)),
                                    7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)),
                                    5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                                    $urandom(), 1'($urandom_range(0, 1)));
        it.op         = OP_READ;
        it.read_index = idx;
        return it;
    endfunction

    task automatic wait_drained();
        while (queued_instrs.size() != 0 || s_tvalid || predicted_profiles.size() != 0)
            @(posedge aclk);
    endtask

    // input driver
    always @(negedge aclk) begin : instr_driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !item_taken) begin
            // hold the current transfer
        end else begin
            item_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (queued_instrs.size() != 0) begin
                cur_item = queued_instrs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= cur_item.op;
                s_tdata  <= {1'b0, cur_item.read_index, cur_item.heap_valid,
                             cur_item.heap_value, cur_item.rs2, cur_item.rs1, cur_item.rd,
                             cur_item.funct7, cur_item.funct3, cur_item.opcode};
                if ($urandom_range(0, 99) < send_idle_pct) send_gap = $urandom_range(1, 4);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : instr_accept
        if (aresetn && s_tvalid && s_tready) begin
            predicted_profiles.push_back(predict_profile(cur_item));
            if (cur_item.op == OP_READ) reads_sent++;
            else records_sent++;
            item_taken = 1'b1;
        end
    end

    always @(negedge aclk) begin : result_sink
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (take_stall > 0) begin
            take_stall--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < take_idle_pct) begin
            take_stall = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge aclk) begin : result_check
        profile_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (predicted_profiles.size() == 0) begin
                $error("result transfer with no prediction pending");
                mismatches++;
            end else begin
                want = predicted_profiles.pop_front();
                results_checked++;
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    mismatches++;
                end
                if (m_tdata[47:0] !== want.kind_count) begin
                    $error("kind_count: expected %0d, got %0d", want.kind_count, m_tdata[47:0]);
                    mismatches++;
                end
                if (m_tdata[95:48] !== want.dest_count) begin
                    $error("dest_count: expected %0d, got %0d", want.dest_count, m_tdata[95:48]);
                    mismatches++;
                end
                if (m_tdata[143:96] !== want.src_count) begin
                    $error("src_count: expected %0d, got %0d", want.src_count, m_tdata[143:96]);
                    mismatches++;
                end
                if (m_tdata[175:144] !== want.heap_max) begin
                    $error("heap_max: expected %0d, got %0d", want.heap_max,
                           $signed(m_tdata[175:144]));
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        retire_item_t it;
        int           pick;
        int           mag;
        logic [2:0]   rm_plan [N_PHASES];

        rm_plan[0] = imp_pkg::RM_RESET;
        rm_plan[1] = 3'd0;
        rm_plan[2] = 3'd7;
        rm_plan[3] = 3'd3;
        rm_plan[4] = 3'd5;

        major_opcodes = '{imp_pkg::OPC_ZERO, imp_pkg::OPC_LOAD, imp_pkg::OPC_STORE,
                          imp_pkg::OPC_OP, imp_pkg::OPC_OPIMM, imp_pkg::OPC_BRANCH,
                          imp_pkg::OPC_LUI, imp_pkg::OPC_AUIPC, imp_pkg::OPC_JAL,
                          imp_pkg::OPC_JALR, imp_pkg::OPC_MULDIV, imp_pkg::OPC_RXBU,
                          imp_pkg::OPC_TXBU, imp_pkg::OPC_FLW, imp_pkg::OPC_FSW,
                          imp_pkg::OPC_FP};
        fp_functs     = '{imp_pkg::F7_FADD, imp_pkg::F7_FSUB, imp_pkg::F7_FMUL,
                          imp_pkg::F7_FDIV, imp_pkg::F7_FSQRT, imp_pkg::F7_FSGNJ,
                          imp_pkg::F7_FCVTSW, imp_pkg::F7_FMVWX, imp_pkg::F7_FMVXW,
                          imp_pkg::F7_FCMP};

        for (int i = 0; i < imp_pkg::KIND_SLOTS; i++) kind_tally[i] = '0;
        for (int i = 0; i < imp_pkg::REG_SLOTS; i++) begin
            dest_tally[i] = '0;
            src_tally[i]  = '0;
        end
        heap_peak  = '0;
        round_mode = imp_pkg::RM_RESET;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                @(negedge aclk);
                cfg_valid <= 1'b1;
                cfg_data  <= rm_plan[ph];
                @(posedge aclk);
                while (!cfg_ready) @(posedge aclk);
                round_mode = cfg_data;
                @(negedge aclk);
                cfg_valid <= 1'b0;
            end

            if (ph == 2 || ph == N_PHASES - 1) begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end else begin
                send_idle_pct = $urandom_range(10, 50);
                take_idle_pct = $urandom_range(10, 50);
            end

            if (ph == 0) begin
                queued_instrs.push_back(record_item(imp_pkg::OPC_ZERO, imp_pkg::F3_SHR,
                                                    7'h7F, 5'd31, 5'd31, 5'd31,
                                                    32'sh8000_0000, 1'b1));
                queued_instrs.push_back(record_item(imp_pkg::OPC_LOAD, imp_pkg::F3_WORD,
                                                    imp_pkg::F7_ZERO, 5'd31, 5'd0, 5'd9,
                                                    32'sd1000, 1'b1));
                queued_instrs.push_back(record_item(imp_pkg::OPC_LOAD, imp_pkg::F3_SLTU,
                                                    imp_pkg::F7_ZERO, 5'd1, 5'd2, 5'd3,
                                                    32'sd5000, 1'b1));
                queued_instrs.push_back(record_item(imp_pkg::OPC_STORE, imp_pkg::F3_WORD,
                                                    imp_pkg::F7_ZERO, 5'd4, 5'd31, 5'd31,
                                                    -32'sd1, 1'b1));
                queued_instrs.push_back(record_item(imp_pkg::OPC_OP, imp_pkg::F3_ADD,
                                                    imp_pkg::F7_ALT, 5'd5, 5'd6, 5'd6,
                                                    32'sd2000, 1'b0));
                queued_instrs.push_back(record_item(imp_pkg::OPC_OP, imp_pkg::F3_SHR,
                                                    7'h7F, 5'd7, 5'd8, 5'd9,
                                                    32'sd3000, 1'b1));
                queued_instrs.push_back(record_item(imp_pkg::OPC_OPIMM, imp_pkg::F3_SHR,
                                                    imp_pkg::F7_ALT, 5'd0, 5'd1, 5'd2,
                                                    32'sd1500, 1'b1));
                queued_instrs.push_back(record_item(imp_pkg::OPC_BRANCH, imp_pkg::F3_TWO,
                                                    imp_pkg::F7_ZERO, 5'd0, 5'd10, 5'd10,
                                                    32'sd0, 1'b0));
                queued_instrs.push_back(record_item(imp_pkg::OPC_MULDIV, imp_pkg::F3_ONE,
                                                    imp_pkg::F7_ZERO, 5'd11, 5'd12,
                                                    imp_pkg::REG_ZERO, 32'sd0, 1'b0));
                queued_instrs.push_back(record_item(imp_pkg::OPC_MULDIV, imp_pkg::F3_ZERO,
                                                    imp_pkg::F7_ZERO, 5'd11, 5'd12, 5'd3,
                                                    32'sd0, 1'b0));
                queued_instrs.push_back(record_item(imp_pkg::OPC_FLW, imp_pkg::F3_WORD,
                                                    imp_pkg::F7_ZERO, 5'd31, 5'd13, 5'd0,
                                                    32'sd0, 1'b0));
                queued_instrs.push_back(record_item(imp_pkg::OPC_FSW, imp_pkg::F3_WORD,
                                                    imp_pkg::F7_ZERO, 5'd0, 5'd13, 5'd31,
                                                    32'sd0, 1'b0));
                queued_instrs.push_back(record_item(imp_pkg::OPC_FP, imp_pkg::RM_RESET,
                                                    imp_pkg::F7_FADD, 5'd1, 5'd2, 5'd2,
                                                    32'sd0, 1'b0));
                queued_instrs.push_back(record_item(imp_pkg::OPC_FP, imp_pkg::F3_ZERO,
                                                    imp_pkg::F7_FDIV, 5'd1, 5'd2, 5'd3,
                                                    32'sd0, 1'b0));
                queued_instrs.push_back(record_item(imp_pkg::OPC_FP, imp_pkg::RM_RESET,
                                                    imp_pkg::F7_FSQRT, 5'd4, 5'd5,
                                                    imp_pkg::REG_ZERO, 32'sd0, 1'b0));
                queued_instrs.push_back(record_item(imp_pkg::OPC_FP, imp_pkg::RM_RESET,
                                                    imp_pkg::F7_FSQRT, 5'd4, 5'd5, 5'd1,
                                                    32'sd0, 1'b0));
                queued_instrs.push_back(record_item(imp_pkg::OPC_FP, imp_pkg::F3_TWO,
                                                    imp_pkg::F7_FSGNJ, 5'd6, 5'd7, 5'd8,
                                                    32'sd0, 1'b0));
                queued_instrs.push_back(record_item(imp_pkg::OPC_FP, imp_pkg::RM_RESET,
                                                    imp_pkg::F7_FCVTSW, 5'd9, 5'd10,
                                                    imp_pkg::REG_ZERO, 32'sd0, 1'b0));
                queued_instrs.push_back(record_item(imp_pkg::OPC_FP, imp_pkg::F3_ZERO,
                                                    imp_pkg::F7_FMVWX, 5'd11, 5'd12,
                                                    imp_pkg::REG_ZERO, 32'sd0, 1'b0));
                queued_instrs.push_back(record_item(imp_pkg::OPC_FP, imp_pkg::F3_ZERO,
                                                    imp_pkg::F7_FMVXW, 5'd13, 5'd14,
                                                    imp_pkg::REG_ZERO, 32'sd0, 1'b0));
                queued_instrs.push_back(record_item(imp_pkg::OPC_FP, imp_pkg::F3_ZERO,
                                                    imp_pkg::F7_FCMP, 5'd15, 5'd16, 5'd17,
                                                    32'sd0, 1'b0));
                queued_instrs.push_back(record_item(imp_pkg::OPC_FP, imp_pkg::F3_AND,
                                                    imp_pkg::F7_FCMP, 5'd15, 5'd16, 5'd17,
                                                    32'sd0, 1'b0));
                queued_instrs.push_back(record_item(imp_pkg::OPC_FP, imp_pkg::RM_RESET,
                                                    7'h7F, 5'd1, 5'd1, 5'd1,
                                                    32'sd0, 1'b0));
                queued_instrs.push_back(read_item(6'd0));
                queued_instrs.push_back(read_item(6'd63));
                queued_instrs.push_back(read_item(6'd33));
            end

            for (int n = 0; n < RANDOM_ITEMS / N_PHASES; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 28) begin
                    it = read_item(6'($urandom_range(0, 63)));
                end else begin
                    mag = int'($urandom() >> $urandom_range(1, 31));
                    it  = record_item(7'($urandom_range(0, 127)), 3'($urandom_range(0, 7)),
                                      7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)),
                                      5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                                      ($urandom_range(0, 3) == 0) ? -mag : mag,
                                      $urandom_range(0, 4) != 0);
                    if (pick < 92)
                        it.opcode = major_opcodes[$urandom_range(0, major_opcodes.size() - 1)];
                    case (it.opcode)
                        imp_pkg::OPC_LOAD, imp_pkg::OPC_STORE, imp_pkg::OPC_FLW,
                        imp_pkg::OPC_FSW: begin
                            if ($urandom_range(0, 3) != 0) it.funct3 = imp_pkg::F3_WORD;
                        end
                        imp_pkg::OPC_OP, imp_pkg::OPC_OPIMM: begin
                            case ($urandom_range(0, 4))
                                0, 1:    it.funct7 = imp_pkg::F7_ZERO;
                                2, 3:    it.funct7 = imp_pkg::F7_ALT;
                                default: ;
                            endcase
                        end
                        imp_pkg::OPC_MULDIV: begin
                            if ($urandom_range(0, 4) != 0) it.funct7 = imp_pkg::F7_ZERO;
                            if ($urandom_range(0, 4) != 0) it.rs2 = imp_pkg::REG_ZERO;
                            if ($urandom_range(0, 5) != 0) it.funct3 = 3'($urandom_range(0, 1));
                        end
                        imp_pkg::OPC_FP: begin
                            if ($urandom_range(0, 6) != 0)
                                it.funct7 = fp_functs[$urandom_range(0, fp_functs.size() - 1)];
                            case ($urandom_range(0, 3))
                                0, 1:    it.funct3 = rm_plan[ph];
                                2:       it.funct3 = 3'($urandom_range(0, 2));
                                default: ;
                            endcase
                            if ($urandom_range(0, 2) != 0) it.rs2 = imp_pkg::REG_ZERO;
                        end
                        default: ;
                    endcase
                end
                queued_instrs.push_back(it);
            end
        end

        // largest heap value last so it does not mask earlier peaks
        queued_instrs.push_back(record_item(imp_pkg::OPC_ZERO, imp_pkg::F3_ZERO,
                                            imp_pkg::F7_ZERO, 5'd0, 5'd0, 5'd0,
                                            32'sh7FFF_FFFF, 1'b1));
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d records (%0d with unknown encodings) and %0d counter reads",
                 records_sent, rejected_items, reads_sent);
        $display("checked %0d results over %0d rounding-mode settings", results_checked,
                 N_PHASES);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
